>>> hdl/wmsb_pkg.sv
// Package for the weighted match score / best select unit.
// Holds field widths, action and error codes, weights, FSM state and command types.
// No dependencies; every other file of the block uses it.
`default_nettype none

package wmsb_pkg;

  // Number of attribute positions that carry a weight in one context.
  localparam int NUM_ATTRIBUTES = 13;
  localparam int POS_W          = $clog2(NUM_ATTRIBUTES + 1);

  // Field widths.
  localparam int ACTION_W = 2;
  localparam int COUNT_W  = 32;
  localparam int TW_W     = 32;
  localparam int DIST_W   = 5;
  localparam int ID_W     = 16;
  localparam int SCORE_W  = 24;
  localparam int ERR_W    = 2;
  localparam int WEIGHT_W = 4;
  localparam int SUM_W    = 40;
  localparam int FRAC_W   = 16;

  // Divider: the quotient is 24 bits once saturation has been ruled out.
  localparam int QUOT_W = SCORE_W;
  localparam int STEP_W = $clog2(QUOT_W);
  localparam int PROD_W = SCORE_W + DIST_W;

  localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

  // Action codes.
  localparam logic [ACTION_W-1:0] ACT_START = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_COUNT = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLOSE = 2'd2;

  // Error codes.
  localparam logic [ERR_W-1:0] ERR_OK          = 2'd0;
  localparam logic [ERR_W-1:0] ERR_ZERO_WEIGHT = 2'd1;
  localparam logic [ERR_W-1:0] ERR_ABORTED     = 2'd2;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIN
  } wmsb_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic scan_clear;
    logic count_add;
    logic close_load;
    logic div_step;
    logic finish;
  } wmsb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic bypass;
    logic div_done;
    logic out_free;
  } wmsb_status_t;

  // Fixed weight for each attribute position; positions past the table weigh zero.
  function automatic logic [WEIGHT_W-1:0] attr_weight(input logic [3:0] pos);
    logic [WEIGHT_W-1:0] w;
    unique case (pos)
      4'd0, 4'd1, 4'd2: w = 4'd10;
      4'd3:             w = 4'd9;
      4'd4, 4'd5:       w = 4'd8;
      4'd6:             w = 4'd6;
      4'd7:             w = 4'd1;
      4'd8, 4'd9:       w = 4'd6;
      4'd10, 4'd11:     w = 4'd3;
      4'd12:            w = 4'd1;
      default:          w = 4'd0;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

>>> hdl/wmsb_in_if.sv
// Input channel interface: valid/ready handshake with the scan item payload.
// Depends on wmsb_pkg for the field widths.
`default_nettype none

interface wmsb_in_if;
  logic                           valid;
  logic                           ready;
  logic [wmsb_pkg::ACTION_W-1:0]  action;
  logic [wmsb_pkg::COUNT_W-1:0]   count;
  logic [wmsb_pkg::TW_W-1:0]      norm_weight;
  logic [wmsb_pkg::DIST_W-1:0]    distinct_types;
  logic [wmsb_pkg::ID_W-1:0]      context_id;

  modport source (
    output valid, action, count, norm_weight, distinct_types, context_id,
    input  ready
  );
  modport sink (
    input  valid, action, count, norm_weight, distinct_types, context_id,
    output ready
  );
endinterface

`default_nettype wire

>>> hdl/wmsb_out_if.sv
// Result channel interface: valid/ready handshake with the score result payload.
// Depends on wmsb_pkg for the field widths.
`default_nettype none

interface wmsb_out_if;
  logic                           valid;
  logic                           ready;
  logic [wmsb_pkg::SCORE_W-1:0]   score;
  logic [wmsb_pkg::ERR_W-1:0]     error;
  logic                           new_best;
  logic [wmsb_pkg::ID_W-1:0]      best_context_id;
  logic                           best_valid;

  modport source (
    output valid, score, error, new_best, best_context_id, best_valid,
    input  ready
  );
  modport sink (
    input  valid, score, error, new_best, best_context_id, best_valid,
    output ready
  );
endinterface

`default_nettype wire

>>> hdl/wmsb_cfg_if.sv
// Configuration write channel interface: valid/ready with the threshold write data.
// Depends on wmsb_pkg for the data width.
`default_nettype none

interface wmsb_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [wmsb_pkg::SCORE_W-1:0]   data;

  modport source (
    output valid, data,
    input  ready
  );
  modport sink (
    input  valid, data,
    output ready
  );
endinterface

`default_nettype wire

>>> hdl/wmsb_ctrl.sv
// Controller FSM: accepts items, sequences the divider and the result write.
// Depends on wmsb_pkg for the state enum and the command/status structs.
`default_nettype none

module wmsb_ctrl (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  input  wire logic [wmsb_pkg::ACTION_W-1:0]  in_action,
  input  wire wmsb_pkg::wmsb_status_t         status,
  output logic                                in_ready,
  output wmsb_pkg::wmsb_cmd_t                 cmd
);
  import wmsb_pkg::*;

  wmsb_state_t state_r;
  wmsb_state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_action)
            ACT_START: cmd.scan_clear = 1'b1;
            ACT_COUNT: cmd.count_add  = 1'b1;
            ACT_CLOSE: begin
              cmd.close_load = 1'b1;
              state_nxt      = status.bypass ? ST_FIN : ST_DIV;
            end
            default: ;
          endcase
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

>>> hdl/wmsb_dp.sv
// Datapath: weighted accumulator, bit-serial divider, scoring, best tracking, result register.
// Depends on wmsb_pkg; driven by commands from wmsb_ctrl.
`default_nettype none

module wmsb_dp (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire wmsb_pkg::wmsb_cmd_t            cmd,
  output wmsb_pkg::wmsb_status_t              status,
  input  wire logic [wmsb_pkg::COUNT_W-1:0]   in_count,
  input  wire logic [wmsb_pkg::TW_W-1:0]      in_norm_weight,
  input  wire logic [wmsb_pkg::DIST_W-1:0]    in_distinct_types,
  input  wire logic [wmsb_pkg::ID_W-1:0]      in_context_id,
  input  wire logic                           cfg_valid,
  input  wire logic [wmsb_pkg::SCORE_W-1:0]   cfg_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [wmsb_pkg::SCORE_W-1:0]        out_score,
  output logic [wmsb_pkg::ERR_W-1:0]          out_error,
  output logic                                out_new_best,
  output logic [wmsb_pkg::ID_W-1:0]           out_best_context_id,
  output logic                                out_best_valid
);
  import wmsb_pkg::*;

  // Scan and context state.
  logic [SCORE_W-1:0] min_score_r;
  logic [SUM_W-1:0]   sum_r;
  logic [POS_W-1:0]   pos_r;
  logic [SCORE_W-1:0] best_score_r;
  logic [ID_W-1:0]    best_id_r;
  logic               have_best_r;
  logic               aborted_r;

  // Close context registers.
  logic [TW_W-1:0]    tw_r;
  logic [DIST_W-1:0]  scale_r;
  logic [ID_W-1:0]    cid_r;
  logic [ERR_W-1:0]   err_r;
  logic               sat_r;

  // Divider registers.
  logic [TW_W-1:0]    rem_r;
  logic [QUOT_W-1:0]  dq_r;
  logic [STEP_W-1:0]  step_r;

  // Result register.
  logic               out_valid_r;
  logic [SCORE_W-1:0] out_score_r;
  logic [ERR_W-1:0]   out_error_r;
  logic               out_new_best_r;
  logic [ID_W-1:0]    out_best_id_r;
  logic               out_best_valid_r;

  logic [WEIGHT_W+COUNT_W-1:0] wprod;
  logic                        count_ok;
  logic [ERR_W-1:0]            close_err;
  logic                        close_sat;
  logic [TW_W:0]               rem_sh;
  logic [TW_W:0]               rem_diff;
  logic                        rem_ge;
  logic [PROD_W-1:0]           sprod;
  logic [SCORE_W-1:0]          score_fin;
  logic                        better;
  logic                        record;

  // Weighted count product and accumulate condition.
  assign wprod    = attr_weight(4'(pos_r)) * in_count;
  assign count_ok = !aborted_r && (pos_r < POS_W'(NUM_ATTRIBUTES));

  // Close classification: error code and quotient saturation test.
  // The quotient overflows 24 bits exactly when sum >= divisor weight * 2^8.
  always_comb begin
    if (aborted_r) begin
      close_err = ERR_ABORTED;
    end else if (in_norm_weight == '0) begin
      close_err = ERR_ZERO_WEIGHT;
    end else begin
      close_err = ERR_OK;
    end
  end
  assign close_sat = sum_r >= {in_norm_weight, 8'd0};

  // One restoring division step.
  assign rem_sh   = {rem_r, dq_r[QUOT_W-1]};
  assign rem_ge   = rem_sh >= {1'b0, tw_r};
  assign rem_diff = rem_sh - {1'b0, tw_r};

  // Final score: scale by distinct types and saturate.
  assign sprod = dq_r * scale_r;
  always_comb begin
    if (err_r != ERR_OK || scale_r == '0) begin
      score_fin = '0;
    end else if (sat_r || sprod > PROD_W'(SCORE_MAX)) begin
      score_fin = SCORE_MAX;
    end else begin
      score_fin = SCORE_W'(sprod);
    end
  end
  assign better = (err_r == ERR_OK) && (score_fin > best_score_r);
  assign record = better && (score_fin > min_score_r);

  // Status to the controller.
  assign status.bypass   = (close_err != ERR_OK) || close_sat || (in_distinct_types == '0);
  assign status.div_done = (step_r == STEP_W'(QUOT_W - 1));
  assign status.out_free = !out_valid_r || out_ready;

  // Control state with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_score_r  <= '0;
      sum_r        <= '0;
      pos_r        <= '0;
      best_score_r <= '0;
      best_id_r    <= '0;
      have_best_r  <= 1'b0;
      aborted_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        min_score_r <= cfg_data;
      end
      if (cmd.scan_clear) begin
        sum_r        <= '0;
        pos_r        <= '0;
        best_score_r <= '0;
        best_id_r    <= '0;
        have_best_r  <= 1'b0;
        aborted_r    <= 1'b0;
      end else if (cmd.count_add && count_ok) begin
        sum_r <= sum_r + SUM_W'(wprod);
        pos_r <= pos_r + 1'b1;
      end else if (cmd.close_load) begin
        sum_r <= '0;
        pos_r <= '0;
        if (close_err == ERR_ZERO_WEIGHT) begin
          aborted_r <= 1'b1;
        end
      end
      if (cmd.finish) begin
        if (better) begin
          best_score_r <= score_fin;
        end
        if (record) begin
          best_id_r   <= cid_r;
          have_best_r <= 1'b1;
        end
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Close and divider payload registers.
  always_ff @(posedge clk) begin
    if (cmd.close_load) begin
      tw_r    <= in_norm_weight;
      scale_r <= in_distinct_types;
      cid_r   <= in_context_id;
      err_r   <= close_err;
      sat_r   <= close_sat;
      rem_r   <= sum_r[SUM_W-1:SUM_W-TW_W];
      dq_r    <= {sum_r[SUM_W-TW_W-1:0], FRAC_W'(0)};
      step_r  <= '0;
    end else if (cmd.div_step) begin
      rem_r  <= rem_ge ? rem_diff[TW_W-1:0] : rem_sh[TW_W-1:0];
      dq_r   <= {dq_r[QUOT_W-2:0], rem_ge};
      step_r <= step_r + 1'b1;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_score_r      <= score_fin;
      out_error_r      <= err_r;
      out_new_best_r   <= record;
      out_best_valid_r <= have_best_r || record;
      if (record) begin
        out_best_id_r <= cid_r;
      end else if (have_best_r) begin
        out_best_id_r <= best_id_r;
      end else begin
        out_best_id_r <= '0;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_score           = out_score_r;
  assign out_error           = out_error_r;
  assign out_new_best        = out_new_best_r;
  assign out_best_context_id = out_best_id_r;
  assign out_best_valid      = out_best_valid_r;

endmodule

`default_nettype wire

>>> hdl/weighted_match_score_best_select_unit.sv
// Weighted match score / best select unit.
// Input channel in_ch carries scan items: start, attribute count or close.
// A start clears the running best and any abort; counts accumulate a weighted
// sum, one count accepted per cycle; a close scores the context and produces
// one result on out_ch. Start and count items produce no result.
// A close that needs a division holds the unit: its transfer loads the divider,
// the one-bit-per-cycle restoring divider runs, and a final step scales,
// compares and writes the result register. A close with an error, a saturated
// quotient or zero distinct types skips the divider and goes straight from its
// transfer to the final step. In both cases the next item can be taken once the
// final step has written the result register.
// While a close is in progress in_ch is not ready; otherwise it is ready.
// The threshold min_score is written through cfg_ch, which is always ready.
// The result register holds one item; if the receiver stalls, the unit keeps
// accepting start and count items, and a later close waits in its final cycle
// until the held result has been transferred.
// Reset (rst_n low, synchronous) clears the threshold, the sum, the best and
// the abort flag, and empties the result register.
// Depends on wmsb_pkg, the three channel interfaces, wmsb_ctrl and wmsb_dp.
`default_nettype none

module weighted_match_score_best_select_unit (
  input  wire logic  clk,
  input  wire logic  rst_n,
  wmsb_in_if.sink    in_ch,
  wmsb_out_if.source out_ch,
  wmsb_cfg_if.sink   cfg_ch
);
  import wmsb_pkg::*;

  wmsb_cmd_t    cmd;
  wmsb_status_t status;
  logic         in_ready;

  // Configuration writes are taken in any cycle.
  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = in_ready;

  // Controller.
  wmsb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .status    (status),
    .in_ready  (in_ready),
    .cmd       (cmd)
  );

  // Datapath.
  wmsb_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .status              (status),
    .in_count            (in_ch.count),
    .in_norm_weight      (in_ch.norm_weight),
    .in_distinct_types   (in_ch.distinct_types),
    .in_context_id       (in_ch.context_id),
    .cfg_valid           (cfg_ch.valid),
    .cfg_data            (cfg_ch.data),
    .out_valid           (out_ch.valid),
    .out_ready           (out_ch.ready),
    .out_score           (out_ch.score),
    .out_error           (out_ch.error),
    .out_new_best        (out_ch.new_best),
    .out_best_context_id (out_ch.best_context_id),
    .out_best_valid      (out_ch.best_valid)
  );

endmodule

`default_nettype wire

>>> tb/tb_weighted_match_score_best_select_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for weighted_match_score_best_select_unit.
// Needs wmsb_pkg, the three channel interfaces and the unit. It drives scans
// of count and close items through a queue-fed driver and scores each close in
// its own model. A monitor compares every result transfer with that model.

module tb_weighted_match_score_best_select_unit;
  import wmsb_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES   = 40;
  localparam int HOLD_CYCLES     = 300;
  localparam int ITEMS_PER_PHASE = 250;
  localparam int NUM_PHASES      = 4;
  localparam int TIMEOUT_NS      = 2_000_000;

  // Weight per attribute position, position 0 in the low nibble.
  localparam logic [63:0] WEIGHT_TABLE = {4'd0, 4'd0, 4'd0, 4'd1, 4'd3, 4'd3, 4'd6, 4'd6,
                                          4'd1, 4'd6, 4'd8, 4'd8, 4'd9, 4'd10, 4'd10, 4'd10};

  typedef enum {SK_ITEM, SK_THRESHOLD, SK_RATES, SK_DRAIN, SK_HOLD} stim_kind_t;

  typedef struct {
    stim_kind_t          kind;
    logic [ACTION_W-1:0] action;
    logic [COUNT_W-1:0]  count;
    logic [TW_W-1:0]     norm_weight;
    logic [DIST_W-1:0]   distinct_types;
    logic [ID_W-1:0]     context_id;
    logic [SCORE_W-1:0]  threshold;
    int                  send_pct;
    int                  recv_pct;
  } stim_entry_t;

  typedef struct {
    logic [SCORE_W-1:0] score;
    logic [ERR_W-1:0]   error;
    logic               new_best;
    logic [ID_W-1:0]    best_context_id;
    logic               best_valid;
  } score_result_t;

  logic clk;
  logic rst_n;

  wmsb_in_if  in_ch ();
  wmsb_out_if out_ch ();
  wmsb_cfg_if cfg_ch ();

  weighted_match_score_best_select_unit DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  stim_entry_t   item_q[$];
  score_result_t score_q[$];

  int   mismatch_cnt = 0;
  int   results_due  = 0;
  int   results_seen;
  int   send_pct;
  int   recv_pct;
  int   hold_cnt;
  int   settle_cycles;
  logic hold_start;
  logic stim_done = 1'b0;

  // Model of the scoring state.
  logic [SUM_W-1:0]   ctx_sum;
  logic [4:0]         ctx_pos;
  logic [SCORE_W-1:0] scan_best_score;
  logic [ID_W-1:0]    scan_best_id;
  logic               scan_has_best;
  logic               scan_aborted;
  logic [SCORE_W-1:0] threshold;

  task automatic flag_mismatch(input string what);
    mismatch_cnt++;
    $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  task automatic queue_item(input logic [ACTION_W-1:0] act, input logic [COUNT_W-1:0] cnt,
                            input logic [TW_W-1:0] tw, input logic [DIST_W-1:0] dt,
                            input logic [ID_W-1:0] cid);
    stim_entry_t e;
    e.kind           = SK_ITEM;
    e.action         = act;
    e.count          = cnt;
    e.norm_weight    = tw;
    e.distinct_types = dt;
    e.context_id     = cid;
    e.threshold      = '0;
    e.send_pct       = 0;
    e.recv_pct       = 0;
    item_q.push_back(e);
  endtask

  task automatic queue_control(input stim_kind_t kind, input logic [SCORE_W-1:0] thr,
                               input int s_pct, input int r_pct);
    stim_entry_t e;
    e.kind           = kind;
    e.action         = ACT_START;
    e.count          = '0;
    e.norm_weight    = '0;
    e.distinct_types = '0;
    e.context_id     = '0;
    e.threshold      = thr;
    e.send_pct       = s_pct;
    e.recv_pct       = r_pct;
    item_q.push_back(e);
  endtask

  // Advances the scoring model by one accepted item and records the result of a close.
  function automatic void apply_scan_item(input logic [ACTION_W-1:0] act,
                                          input logic [COUNT_W-1:0] cnt,
                                          input logic [TW_W-1:0] tw,
                                          input logic [DIST_W-1:0] dt,
                                          input logic [ID_W-1:0] cid);
    score_result_t r;
    logic [SUM_W+FRAC_W-1:0] quot;
    logic [PROD_W-1:0]       scaled;
    r.score           = '0;
    r.error           = ERR_OK;
    r.new_best        = 1'b0;
    r.best_context_id = '0;
    r.best_valid      = 1'b0;
    case (act)
      ACT_START: begin
        ctx_sum         = '0;
        ctx_pos         = '0;
        scan_best_score = '0;
        scan_best_id    = '0;
        scan_has_best   = 1'b0;
        scan_aborted    = 1'b0;
      end
      ACT_COUNT: begin
        if (!scan_aborted && ctx_pos < NUM_ATTRIBUTES) begin
          ctx_sum = ctx_sum + SUM_W'(WEIGHT_TABLE[ctx_pos*4 +: 4]) * SUM_W'(cnt);
          ctx_pos = ctx_pos + 5'd1;
        end
      end
      ACT_CLOSE: begin
        if (scan_aborted) begin
          r.error = ERR_ABORTED;
        end else if (tw == '0) begin
          r.error      = ERR_ZERO_WEIGHT;
          scan_aborted = 1'b1;
        end else begin
          // Q8.16 quotient, then scale by the distinct count, saturating both steps.
          quot = {ctx_sum, {FRAC_W{1'b0}}} / {{(SUM_W+FRAC_W-TW_W){1'b0}}, tw};
          if (dt == '0) begin
            r.score = '0;
          end else if (quot > SCORE_MAX) begin
            r.score = SCORE_MAX;
          end else begin
            scaled  = PROD_W'(quot[SCORE_W-1:0]) * PROD_W'(dt);
            r.score = (scaled > SCORE_MAX) ? SCORE_MAX : scaled[SCORE_W-1:0];
          end
          if (r.score > scan_best_score) begin
            scan_best_score = r.score;
            if (scan_best_score > threshold) begin
              scan_best_id  = cid;
              scan_has_best = 1'b1;
              r.new_best    = 1'b1;
            end
          end
        end
        ctx_sum           = '0;
        ctx_pos           = '0;
        r.best_valid      = scan_has_best;
        r.best_context_id = scan_has_best ? scan_best_id : '0;
        score_q.push_back(r);
        results_due++;
      end
      default: begin
      end
    endcase
  endfunction

  // Clock, and known values on every input from time zero.
  initial begin
    clk                  = 1'b0;
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.action         = '0;
    in_ch.count          = '0;
    in_ch.norm_weight    = '0;
    in_ch.distinct_types = '0;
    in_ch.context_id     = '0;
    out_ch.ready         = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.data          = '0;
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Driver: offers queued items and threshold writes, and updates the model on each transfer.
  always @(posedge clk) begin : drive_proc
    stim_entry_t head;
    logic        offer_in;
    logic        offer_cfg;
    logic        hold_pulse;
    logic        drained;
    if (!rst_n) begin
      in_ch.valid     <= 1'b0;
      cfg_ch.valid    <= 1'b0;
      hold_start      <= 1'b0;
      stim_done       <= 1'b0;
      send_pct        <= 0;
      recv_pct        <= 0;
      settle_cycles   = 0;
      ctx_sum         = '0;
      ctx_pos         = '0;
      scan_best_score = '0;
      scan_best_id    = '0;
      scan_has_best   = 1'b0;
      scan_aborted    = 1'b0;
      threshold       = '0;
    end else begin
      offer_in   = in_ch.valid && !in_ch.ready;
      offer_cfg  = cfg_ch.valid && !cfg_ch.ready;
      hold_pulse = 1'b0;
      if (in_ch.valid && in_ch.ready) begin
        apply_scan_item(in_ch.action, in_ch.count, in_ch.norm_weight,
                        in_ch.distinct_types, in_ch.context_id);
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        threshold = cfg_ch.data;
      end
      drained       = results_seen >= results_due;
      settle_cycles = (drained && !in_ch.valid) ? settle_cycles + 1 : 0;

      if (!offer_in && !offer_cfg && item_q.size() != 0) begin
        head = item_q[0];
        case (head.kind)
          SK_ITEM: begin
            if ($urandom_range(0, 99) >= send_pct) begin
              offer_in             = 1'b1;
              in_ch.action         <= head.action;
              in_ch.count          <= head.count;
              in_ch.norm_weight    <= head.norm_weight;
              in_ch.distinct_types <= head.distinct_types;
              in_ch.context_id     <= head.context_id;
              void'(item_q.pop_front());
            end
          end
          SK_THRESHOLD: begin
            if (settle_cycles >= SETTLE_CYCLES) begin
              offer_cfg   = 1'b1;
              cfg_ch.data <= head.threshold;
              void'(item_q.pop_front());
            end
          end
          SK_RATES: begin
            send_pct <= head.send_pct;
            recv_pct <= head.recv_pct;
            void'(item_q.pop_front());
          end
          SK_DRAIN: begin
            if (drained) begin
              void'(item_q.pop_front());
            end
          end
          SK_HOLD: begin
            hold_pulse = 1'b1;
            void'(item_q.pop_front());
          end
          default: begin
          end
        endcase
      end
      in_ch.valid  <= offer_in;
      cfg_ch.valid <= offer_cfg;
      hold_start   <= hold_pulse;
      stim_done    <= (item_q.size() == 0) && !offer_in && !offer_cfg;
    end
  end

  // Long receiver hold-off, counted here so the driver keeps offering items meanwhile.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_cnt <= 0;
    end else if (hold_start) begin
      hold_cnt <= HOLD_CYCLES;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // Monitor: checks each result transfer against the oldest predicted score.
  always @(posedge clk) begin : result_check
    score_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      results_seen <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen <= results_seen + 1;
        if (score_q.size() == 0) begin
          flag_mismatch($sformatf("result with nothing expected, score %h", out_ch.score));
        end else begin
          want = score_q.pop_front();
          if (out_ch.score !== want.score)
            flag_mismatch($sformatf("score %h, expected %h", out_ch.score, want.score));
          if (out_ch.error !== want.error)
            flag_mismatch($sformatf("error %0d, expected %0d", out_ch.error, want.error));
          if (out_ch.new_best !== want.new_best)
            flag_mismatch($sformatf("new_best %b, expected %b", out_ch.new_best,
                                    want.new_best));
          if (out_ch.best_context_id !== want.best_context_id)
            flag_mismatch($sformatf("best_context_id %h, expected %h",
                                    out_ch.best_context_id, want.best_context_id));
          if (out_ch.best_valid !== want.best_valid)
            flag_mismatch($sformatf("best_valid %b, expected %b", out_ch.best_valid,
                                    want.best_valid));
        end
      end
      out_ch.ready <= (hold_cnt == 0) && !hold_start && ($urandom_range(0, 99) >= recv_pct);
    end
  end

  // Stimulus: a directed opening, then random scans in several idling phases.
  initial begin : stimulus
    int                 added;
    int                 roll;
    int                 n_ctx;
    int                 n_cnt;
    int                 sel;
    bit                 held;
    bit                 paused;
    logic [COUNT_W-1:0] cnt;
    logic [TW_W-1:0]    tw;
    logic [DIST_W-1:0]  dt;
    logic [SCORE_W-1:0] thr;
    int                 phase_send[NUM_PHASES];
    int                 phase_recv[NUM_PHASES];
    held       = 0;
    paused     = 0;
    phase_send = '{0, 69, 0, 9};
    phase_recv = '{0, 0, 69, 9};

    // Directed part, threshold still at its reset value of zero.
    queue_item(ACT_START, '1, '1, '1, '1);
    queue_item(ACT_COUNT, '1, '0, '0, '0);
    queue_item(ACT_CLOSE, '0, 32'd1, 5'd1, 16'h1234);              // quotient saturates
    queue_item(ACT_COUNT, 32'd5, '1, '1, '1);
    queue_item(ACT_CLOSE, '1, '1, 5'd16, 16'hFFFF);                // tiny score, keeps best
    queue_item(ACT_COUNT, '0, '0, '0, '0);
    queue_item(ACT_COUNT, 32'd3, '0, '0, '0);
    queue_item(ACT_CLOSE, '0, 32'd7, 5'd0, 16'h0000);              // zero distinct types
    queue_item(ACT_CLOSE, '0, '0, 5'd31, 16'hFFFF);                // zero weight aborts scan
    queue_item(ACT_COUNT, 32'd7, '0, '0, '0);                      // ignored while aborted
    queue_item(ACT_CLOSE, '0, 32'd5, 5'd3, 16'h0001);              // skipped close
    queue_item(ACT_UNUSED, '1, '1, '1, '1);                        // meaningless action
    queue_item(ACT_START, '0, '0, '0, '0);
    queue_item(ACT_CLOSE, '0, 32'd3, 5'd1, 16'h0002);              // empty context
    queue_item(ACT_COUNT, 32'd2, '0, '0, '0);
    queue_item(ACT_COUNT, 32'd2, '0, '0, '0);
    queue_item(ACT_CLOSE, '0, 32'd1, 5'd31, 16'h00FF);             // scaled product saturates
    queue_item(ACT_COUNT, 32'd4, '0, '0, '0);
    queue_item(ACT_CLOSE, '0, 32'd3, 5'd2, 16'h0042);

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        1:       thr = SCORE_MAX;
        2:       thr = '0;
        default: thr = SCORE_W'($urandom_range(0, 6 << FRAC_W));
      endcase
      queue_control(SK_THRESHOLD, thr, 0, 0);
      queue_control(SK_RATES, '0, phase_send[p], phase_recv[p]);
      added = 0;
      while (added < ITEMS_PER_PHASE) begin
        if (p == 0 && !held && added >= 60) begin
          queue_control(SK_HOLD, '0, 0, 0);
          held = 1;
        end
        if (p == 1 && !paused && added >= 120) begin
          queue_control(SK_DRAIN, '0, 0, 0);
          paused = 1;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
          queue_item(ACT_UNUSED, $urandom, $urandom, DIST_W'($urandom), ID_W'($urandom));
        end else if (roll < 6) begin
          queue_item(ACT_COUNT, $urandom, $urandom, DIST_W'($urandom), ID_W'($urandom));
          added++;
        end else begin
          // Mostly a well-formed scan; a few continue the previous one without a start.
          if (roll >= 12) begin
            queue_item(ACT_START, $urandom, $urandom, DIST_W'($urandom), ID_W'($urandom));
            added++;
          end
          n_ctx = $urandom_range(1, 6);
          repeat (n_ctx) begin
            n_cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : NUM_ATTRIBUTES;
            repeat (n_cnt) begin
              sel = $urandom_range(0, 19);
              case (sel)
                0:       cnt = '1;
                1:       cnt = $urandom;
                2:       cnt = '0;
                default: cnt = $urandom_range(0, 20);
              endcase
              queue_item(ACT_COUNT, cnt, $urandom, DIST_W'($urandom), ID_W'($urandom));
              added++;
            end
            sel = $urandom_range(0, 24);
            case (sel)
              0:       tw = '0;
              1:       tw = $urandom;
              2:       tw = 32'd1;
              3:       tw = '1;
              default: tw = $urandom_range(1, 3000);
            endcase
            dt = ($urandom_range(0, 9) == 0) ? DIST_W'($urandom) : DIST_W'($urandom_range(0, 16));
            queue_item(ACT_CLOSE, $urandom, tw, dt, ID_W'($urandom));
            added++;
          end
        end
      end
    end

    // Wait for all results, then a quiet stretch in which nothing more may arrive.
    @(posedge clk);
    while (!(stim_done && results_seen >= results_due)) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (score_q.size() != 0) begin
      flag_mismatch($sformatf("%0d expected results never arrived", score_q.size()));
    end
    if (mismatch_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Hard limit on the run.
  initial begin
    #(TIMEOUT_NS);
    flag_mismatch($sformatf("timeout with %0d results still expected", score_q.size()));
    $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> files.f
hdl/wmsb_pkg.sv
hdl/wmsb_in_if.sv
hdl/wmsb_out_if.sv
hdl/wmsb_cfg_if.sv
hdl/wmsb_ctrl.sv
hdl/wmsb_dp.sv
hdl/weighted_match_score_best_select_unit.sv
tb/tb_weighted_match_score_best_select_unit.sv
